// ===== src/lsid_pkg.sv =====
// lsid_pkg: shared types and constants for the link-state install decision core.
// Action and compare codes, register map and filter area kinds.
// No dependencies.
package lsid_pkg;

    localparam int unsigned AddrWidth = 4;

    // register byte addresses, word index in paddr[3:2]
    localparam logic [1:0] RegAreaKind   = 2'd0;
    localparam logic [1:0] RegMaxAge     = 2'd1;
    localparam logic [1:0] RegMaxAgeDiff = 2'd2;

    localparam logic [2:0] AreaKindReset   = 3'd0;
    localparam logic [15:0] MaxAgeReset    = 16'd3600;
    localparam logic [15:0] MaxAgeDiffReset = 16'd900;

    typedef enum logic [2:0] {
        AREA_NORMAL        = 3'd0,
        AREA_STUB          = 3'd1,
        AREA_TOTALLY_STUB  = 3'd2,
        AREA_NSSA          = 3'd3,
        AREA_TOTALLY_NSSA  = 3'd4
    } t_area;

    localparam logic [3:0] TypeInterNet    = 4'd3;
    localparam logic [3:0] TypeInterRouter = 4'd4;
    localparam logic [3:0] TypeExternal    = 4'd5;
    localparam logic [3:0] TypeNssa        = 4'd7;
    localparam logic [3:0] TypeSpfFirst    = 4'd1;
    localparam logic [3:0] TypeSpfLast     = 4'd4;

    typedef enum logic [2:0] {
        ACT_FILTERED  = 3'd0,
        ACT_REJECT    = 3'd1,
        ACT_OLDER     = 3'd2,
        ACT_DUPLICATE = 3'd3,
        ACT_FLUSH     = 3'd4,
        ACT_FIGHT     = 3'd5,
        ACT_INSTALL   = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        CMP_NONE  = 2'd0,
        CMP_OLDER = 2'd1,
        CMP_SAME  = 2'd2,
        CMP_NEWER = 2'd3
    } t_cmp;

    typedef struct packed {
        logic [3:0]         record_type;
        logic               checksum_ok;
        logic               self_origin;
        logic signed [31:0] new_seq;
        logic [15:0]        new_sum;
        logic [15:0]        new_age;
        logic               stored_present;
        logic signed [31:0] stored_seq;
        logic [15:0]        stored_sum;
        logic [15:0]        stored_age;
        logic               bodies_equal;
    } t_item;

    typedef struct packed {
        t_action action_code;
        t_cmp    compare_code;
        logic    flood_flag;
        logic    store_flag;
        logic    topo_changed;
        logic    spf_relevant;
        logic    fight_back;
        logic    refresh_only;
    } t_result;

endpackage

// ===== src/link_state_install_decision_core.sv =====
// link_state_install_decision_core: area filter, header compare and install decision.
// Uses lsid_pkg for codes, register map and the item/result structs.
// The item passes the input register, then the result register, before o_result_valid
// rises with the result word.
// Throughput: one item per cycle, busy is never asserted. Synchronous active-low
// reset clears the valid pipeline and loads area_kind 0, max_age 3600, max_age_diff 900.
// Results cannot be held off by the receiver; each strobe lasts one cycle.
module link_state_install_decision_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            start,
    output logic                            busy,
    input  logic [3:0]                      i_record_type,
    input  logic                            i_checksum_ok,
    input  logic                            i_self_origin,
    input  logic signed [31:0]              i_new_seq,
    input  logic [15:0]                     i_new_sum,
    input  logic [15:0]                     i_new_age,
    input  logic                            i_stored_present,
    input  logic signed [31:0]              i_stored_seq,
    input  logic [15:0]                     i_stored_sum,
    input  logic [15:0]                     i_stored_age,
    input  logic                            i_bodies_equal,
    // results
    output logic                            o_result_valid,
    output logic [2:0]                      o_action_code,
    output logic [1:0]                      o_compare_code,
    output logic                            o_flood_flag,
    output logic                            o_store_flag,
    output logic                            o_topo_changed,
    output logic                            o_spf_relevant,
    output logic                            o_fight_back,
    output logic                            o_refresh_only,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lsid_pkg::AddrWidth-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [2:0]       r_area_kind;
    logic [15:0]      r_max_age;
    logic [15:0]      r_max_age_diff;
    logic             cfg_wr;

    lsid_pkg::t_item   r_item;
    logic              r_item_vld;
    lsid_pkg::t_result r_res;
    lsid_pkg::t_result n_res;
    logic              r_res_vld;

    logic              accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_kind    <= lsid_pkg::AreaKindReset;
            r_max_age      <= lsid_pkg::MaxAgeReset;
            r_max_age_diff <= lsid_pkg::MaxAgeDiffReset;
        end else if (cfg_wr) begin
            if (paddr[3:2] == lsid_pkg::RegAreaKind)   r_area_kind    <= pwdata[2:0];
            if (paddr[3:2] == lsid_pkg::RegMaxAge)     r_max_age      <= pwdata[15:0];
            if (paddr[3:2] == lsid_pkg::RegMaxAgeDiff) r_max_age_diff <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[3:2] == lsid_pkg::RegAreaKind)   prdata = {29'd0, r_area_kind};
        if (paddr[3:2] == lsid_pkg::RegMaxAge)     prdata = {16'd0, r_max_age};
        if (paddr[3:2] == lsid_pkg::RegMaxAgeDiff) prdata = {16'd0, r_max_age_diff};
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
        end else begin
            r_item_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.record_type    <= i_record_type;
            r_item.checksum_ok    <= i_checksum_ok;
            r_item.self_origin    <= i_self_origin;
            r_item.new_seq        <= i_new_seq;
            r_item.new_sum        <= i_new_sum;
            r_item.new_age        <= i_new_age;
            r_item.stored_present <= i_stored_present;
            r_item.stored_seq     <= i_stored_seq;
            r_item.stored_sum     <= i_stored_sum;
            r_item.stored_age     <= i_stored_age;
            r_item.bodies_equal   <= i_bodies_equal;
        end
    end

    // decision logic
    logic        filt;
    logic        area_nssa;
    logic        spf;
    logic        new_max;
    logic        old_max;
    logic [15:0] age_diff;
    lsid_pkg::t_cmp cmp;

    always_comb begin
        area_nssa = (r_area_kind == lsid_pkg::AREA_NSSA) ||
                    (r_area_kind == lsid_pkg::AREA_TOTALLY_NSSA);
        filt = 1'b0;
        if (r_item.record_type == lsid_pkg::TypeInterNet) begin
            filt = (r_area_kind == lsid_pkg::AREA_TOTALLY_STUB) ||
                   (r_area_kind == lsid_pkg::AREA_TOTALLY_NSSA);
        end else if (r_item.record_type == lsid_pkg::TypeInterRouter) begin
            filt = (r_area_kind != lsid_pkg::AREA_NORMAL);
        end else if (r_item.record_type == lsid_pkg::TypeExternal) begin
            filt = (r_area_kind != lsid_pkg::AREA_NORMAL);
        end else if (r_item.record_type == lsid_pkg::TypeNssa) begin
            filt = !area_nssa;
        end

        spf = (r_item.record_type >= lsid_pkg::TypeSpfFirst) &&
              (r_item.record_type <= lsid_pkg::TypeSpfLast);
        new_max  = r_item.new_age >= r_max_age;
        old_max  = r_item.stored_age >= r_max_age;
        age_diff = (r_item.new_age > r_item.stored_age) ?
                   r_item.new_age - r_item.stored_age :
                   r_item.stored_age - r_item.new_age;

        // order: sequence, checksum, max-age state, large age gap
        priority if (r_item.new_seq != r_item.stored_seq) begin
            cmp = (r_item.new_seq > r_item.stored_seq) ? lsid_pkg::CMP_NEWER
                                                       : lsid_pkg::CMP_OLDER;
        end else if (r_item.new_sum != r_item.stored_sum) begin
            cmp = (r_item.new_sum > r_item.stored_sum) ? lsid_pkg::CMP_NEWER
                                                       : lsid_pkg::CMP_OLDER;
        end else if (new_max != old_max) begin
            cmp = new_max ? lsid_pkg::CMP_NEWER : lsid_pkg::CMP_OLDER;
        end else if (age_diff > r_max_age_diff) begin
            cmp = (r_item.new_age < r_item.stored_age) ? lsid_pkg::CMP_NEWER
                                                       : lsid_pkg::CMP_OLDER;
        end else begin
            cmp = lsid_pkg::CMP_SAME;
        end

        n_res = '0;
        n_res.action_code  = lsid_pkg::ACT_FILTERED;
        n_res.compare_code = lsid_pkg::CMP_NONE;
        if (!filt) begin
            n_res.spf_relevant = spf;
            priority if (!r_item.checksum_ok) begin
                n_res.action_code = lsid_pkg::ACT_REJECT;
            end else if (!r_item.stored_present) begin
                n_res.flood_flag = 1'b1;
                n_res.store_flag = 1'b1;
                if (new_max) begin
                    n_res.action_code = lsid_pkg::ACT_FLUSH;
                end else begin
                    n_res.action_code  = lsid_pkg::ACT_INSTALL;
                    n_res.topo_changed = spf;
                end
            end else begin
                n_res.compare_code = cmp;
                priority if (cmp == lsid_pkg::CMP_OLDER) begin
                    n_res.action_code = lsid_pkg::ACT_OLDER;
                end else if (cmp == lsid_pkg::CMP_SAME) begin
                    n_res.action_code = lsid_pkg::ACT_DUPLICATE;
                end else if (new_max) begin
                    n_res.action_code  = lsid_pkg::ACT_FLUSH;
                    n_res.store_flag   = 1'b1;
                    n_res.flood_flag   = 1'b1;
                    n_res.topo_changed = spf;
                end else if (r_item.self_origin &&
                             (r_item.new_seq >= r_item.stored_seq)) begin
                    n_res.action_code = lsid_pkg::ACT_FIGHT;
                    n_res.fight_back  = 1'b1;
                    n_res.flood_flag  = 1'b1;
                end else begin
                    n_res.action_code  = lsid_pkg::ACT_INSTALL;
                    n_res.store_flag   = 1'b1;
                    n_res.flood_flag   = 1'b1;
                    n_res.topo_changed = spf && !r_item.bodies_equal;
                    n_res.refresh_only = spf && r_item.bodies_equal;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= r_item_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_item_vld) begin
            r_res <= n_res;
        end
    end

    assign o_result_valid = r_res_vld;
    assign o_action_code  = r_res.action_code;
    assign o_compare_code = r_res.compare_code;
    assign o_flood_flag   = r_res.flood_flag;
    assign o_store_flag   = r_res.store_flag;
    assign o_topo_changed = r_res.topo_changed;
    assign o_spf_relevant = r_res.spf_relevant;
    assign o_fight_back   = r_res.fight_back;
    assign o_refresh_only = r_res.refresh_only;

    // every strobe comes from an accepted start, via the input register
    a_strobe_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_item_vld) && $past(accept, 2))
        else $error("result strobe without accepted item");

    a_filtered_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_action_code == lsid_pkg::ACT_FILTERED) |->
        (o_compare_code == lsid_pkg::CMP_NONE && !o_flood_flag && !o_store_flag &&
         !o_topo_changed && !o_spf_relevant && !o_fight_back && !o_refresh_only))
        else $error("filtered result carries flags");

    a_fight_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_fight_back) |->
        (o_flood_flag && !o_store_flag && o_compare_code == lsid_pkg::CMP_NEWER))
        else $error("fight back without newer compare");

    a_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_refresh_only) |->
        (!o_topo_changed && o_store_flag && o_action_code == lsid_pkg::ACT_INSTALL))
        else $error("refresh with topology change");

endmodule
